/* rtl/cic_pkg.sv */
// Shared types and constants for the cached inverse colormap.
package cic_pkg;

    localparam int DEF_PALETTE_DEPTH   = 256;
    localparam int DEF_RED_CELL_BITS   = 5;
    localparam int DEF_GREEN_CELL_BITS = 6;
    localparam int DEF_BLUE_CELL_BITS  = 5;

    localparam int RED_SCALE   = 2;
    localparam int GRN_SCALE   = 3;
    localparam int BLU_SCALE   = 1;
    localparam int BOX_AXIS_W  = 3;
    localparam int BOX_W       = 3 * BOX_AXIS_W;
    localparam int BOX_COUNT   = 1 << BOX_W;
    localparam int EPOCH_W     = 8;
    localparam int DIST_W      = 21;
    localparam int COUNT_W     = 9;

    typedef enum logic {
        REQ_PALETTE = 1'b0,
        REQ_PIXEL   = 1'b1
    } t_req;

    typedef struct packed {
        t_req             kind;
        logic [7:0]       entry;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [BOX_W-1:0] box;
    } t_item;

    typedef struct packed {
        logic sweeping;
    } t_back_stat;

endpackage

/* rtl/cic_if.sv */
// Channel interfaces: request, queued work item and result.
interface cic_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] entry_index;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    modport source(output valid, req_type, entry_index, in_red, in_green, in_blue,
                   input ready);
    modport sink(input valid, req_type, entry_index, in_red, in_green, in_blue,
                 output ready);
endinterface

interface cic_item_if;
    logic          valid;
    logic          ready;
    cic_pkg::t_item item;
    modport source(output valid, item, input ready);
    modport sink(input valid, item, output ready);
endinterface

interface cic_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] palette_index;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    modport source(output valid, palette_index, out_red, out_green, out_blue,
                   input ready);
    modport sink(input valid, palette_index, out_red, out_green, out_blue,
                 output ready);
endinterface

/* rtl/cached_inverse_colormap.sv */
// Top level of the cached inverse colormap.
// Maps pixels to the nearest loaded palette entry through a lazily filled cell
// table. Transactions are taken one at a time by the back end behind a
// four-entry queue. A pixel whose box is cached passes through the tag check,
// cell read, palette read and output states. A miss first fills every cell of
// its box (128 cells by default) through the single distance pipeline, which
// examines one palette entry per cycle. After reset, and after every 255th
// cache clear, all 512 entries of the box tag memory are swept, during which
// no request is taken.
module cached_inverse_colormap #(
    parameter int PALETTE_DEPTH   = cic_pkg::DEF_PALETTE_DEPTH,
    parameter int RED_CELL_BITS   = cic_pkg::DEF_RED_CELL_BITS,
    parameter int GREEN_CELL_BITS = cic_pkg::DEF_GREEN_CELL_BITS,
    parameter int BLUE_CELL_BITS  = cic_pkg::DEF_BLUE_CELL_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [cic_pkg::COUNT_W-1:0] i_cfg_data,
    cic_req_if.sink                     i_req,
    cic_res_if.source                   o_res
);
    import cic_pkg::*;

    t_back_stat stat;
    cic_item_if front_q ();
    cic_item_if q_back ();

    cic_front #(
        .PALETTE_DEPTH   (PALETTE_DEPTH),
        .RED_CELL_BITS   (RED_CELL_BITS),
        .GREEN_CELL_BITS (GREEN_CELL_BITS),
        .BLUE_CELL_BITS  (BLUE_CELL_BITS)
    ) u_front (
        .i_req  (i_req),
        .i_stat (stat),
        .o_item (front_q)
    );

    cic_queue #(
        .DEPTH (4)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_q),
        .o_pop   (q_back)
    );

    cic_back #(
        .PALETTE_DEPTH   (PALETTE_DEPTH),
        .RED_CELL_BITS   (RED_CELL_BITS),
        .GREEN_CELL_BITS (GREEN_CELL_BITS),
        .BLUE_CELL_BITS  (BLUE_CELL_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_item     (q_back),
        .o_stat     (stat),
        .o_res      (o_res)
    );

endmodule

/* rtl/cic_queue.sv */
// Small FIFO of work items between the front and back ends.
module cic_queue #(
    parameter int DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cic_item_if.sink    i_push,
    cic_item_if.source  o_pop
);
    import cic_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_item          r_mem [DEPTH];
    logic [AW-1:0]  r_wp;
    logic [AW-1:0]  r_rp;
    logic [AW:0]    r_cnt;
    logic           push;
    logic           pop;

    assign i_push.ready = (r_cnt != (AW+1)'(DEPTH));
    assign o_pop.valid  = (r_cnt != '0);
    assign o_pop.item   = r_mem[r_rp];
    assign push = i_push.valid && i_push.ready;
    assign pop  = o_pop.valid && o_pop.ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push.item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* rtl/cic_front.sv */
// Front end: accepts requests, drops out-of-range palette writes, tags pixels with their box.
module cic_front #(
    parameter int PALETTE_DEPTH   = cic_pkg::DEF_PALETTE_DEPTH,
    parameter int RED_CELL_BITS   = cic_pkg::DEF_RED_CELL_BITS,
    parameter int GREEN_CELL_BITS = cic_pkg::DEF_GREEN_CELL_BITS,
    parameter int BLUE_CELL_BITS  = cic_pkg::DEF_BLUE_CELL_BITS
) (
    cic_req_if.sink        i_req,
    input  cic_pkg::t_back_stat i_stat,
    cic_item_if.source     o_item
);
    import cic_pkg::*;

    localparam int RB = 8 - BOX_AXIS_W;

    logic in_range;
    logic is_pixel;

    assign is_pixel = (i_req.req_type == REQ_PIXEL);
    assign in_range = ({1'b0, i_req.entry_index} < COUNT_W'(PALETTE_DEPTH));

    // top three bits of each channel select the box, whatever the cell width
    assign o_item.item.kind  = t_req'(i_req.req_type);
    assign o_item.item.entry = i_req.entry_index;
    assign o_item.item.red   = i_req.in_red;
    assign o_item.item.green = i_req.in_green;
    assign o_item.item.blue  = i_req.in_blue;
    assign o_item.item.box   = {i_req.in_red[7:RB], i_req.in_green[7:RB],
                                i_req.in_blue[7:RB]};

    assign o_item.valid = i_req.valid && !i_stat.sweeping && (is_pixel || in_range);
    assign i_req.ready  = !i_stat.sweeping && (o_item.ready || (!is_pixel && !in_range));

endmodule

/* rtl/cic_back.sv */
// Back end: palette store, box tags, cell table, nearest-color search and result register.
module cic_back #(
    parameter int PALETTE_DEPTH   = cic_pkg::DEF_PALETTE_DEPTH,
    parameter int RED_CELL_BITS   = cic_pkg::DEF_RED_CELL_BITS,
    parameter int GREEN_CELL_BITS = cic_pkg::DEF_GREEN_CELL_BITS,
    parameter int BLUE_CELL_BITS  = cic_pkg::DEF_BLUE_CELL_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [cic_pkg::COUNT_W-1:0] i_cfg_data,
    cic_item_if.sink                  i_item,
    output cic_pkg::t_back_stat       o_stat,
    cic_res_if.source                 o_res
);
    import cic_pkg::*;

    localparam int RS    = 8 - RED_CELL_BITS;
    localparam int GS    = 8 - GREEN_CELL_BITS;
    localparam int BS    = 8 - BLUE_CELL_BITS;
    localparam int RBL   = RED_CELL_BITS - BOX_AXIS_W;
    localparam int GBL   = GREEN_CELL_BITS - BOX_AXIS_W;
    localparam int BBL   = BLUE_CELL_BITS - BOX_AXIS_W;
    localparam int LCL   = RBL + GBL + BBL;
    localparam int LW    = LCL + 1;
    localparam int CW    = RED_CELL_BITS + GREEN_CELL_BITS + BLUE_CELL_BITS;
    localparam int CELLS = 1 << CW;
    localparam int PAW   = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam logic [7:0]  RHALF = 8'((1 << RS) >> 1);
    localparam logic [7:0]  GHALF = 8'((1 << GS) >> 1);
    localparam logic [7:0]  BHALF = 8'((1 << BS) >> 1);
    localparam logic [15:0] RMASK = 16'((1 << RBL) - 1);
    localparam logic [15:0] GMASK = 16'((1 << GBL) - 1);
    localparam logic [15:0] BMASK = 16'((1 << BBL) - 1);
    localparam logic [LW-1:0] LAST_LOCAL = LW'((1 << LCL) - 1);

    typedef enum logic [6:0] {
        ST_SWEEP = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_CHK   = 7'b0000100,
        ST_FILL  = 7'b0001000,
        ST_RDC   = 7'b0010000,
        ST_RDP   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } t_state;

    logic [23:0]        pal_mem [PALETTE_DEPTH];
    logic [EPOCH_W-1:0] tag_mem [BOX_COUNT];
    logic [7:0]         cell_mem [CELLS];

    t_state              r_state;
    t_item               r_item;
    logic [EPOCH_W-1:0]  r_epoch;
    logic [BOX_W-1:0]    r_sw;
    logic [COUNT_W-1:0]  r_count;
    logic [COUNT_W-1:0]  r_k;
    logic [LW-1:0]       r_local;
    logic                r_v1;
    logic                r_v2;
    logic [PAW-1:0]      r_k1;
    logic [PAW-1:0]      r_k2;
    logic [17:0]         r_sqr;
    logic [19:0]         r_sqg;
    logic [15:0]         r_sqb;
    logic [DIST_W-1:0]   r_bestd;
    logic [7:0]          r_best;
    logic [23:0]         r_pal_q;
    logic [EPOCH_W-1:0]  r_tag_q;
    logic [7:0]          r_cell_q;
    logic [7:0]          r_idx;
    logic                r_ov;
    logic [7:0]          r_o_idx;
    logic [23:0]         r_o_rgb;

    logic                pop;
    logic                clr;
    logic                issue;
    logic                drained;
    logic [COUNT_W-1:0]  cnt_clamped;
    logic [PAW-1:0]      pal_ra;
    logic [7:0]          rc_l;
    logic [7:0]          gc_l;
    logic [7:0]          bc_l;
    logic [7:0]          rc_f;
    logic [7:0]          gc_f;
    logic [7:0]          bc_f;
    logic [7:0]          cr;
    logic [7:0]          cg;
    logic [7:0]          cb;
    logic [15:0]         loc16;
    logic [CW-1:0]       look_addr;
    logic [CW-1:0]       fill_addr;
    logic [7:0]          dr;
    logic [7:0]          dg;
    logic [7:0]          db;
    logic [8:0]          ar;
    logic [9:0]          ag;
    logic [DIST_W-1:0]   dsum;

    assign o_stat.sweeping = (r_state == ST_SWEEP);
    assign i_item.ready    = (r_state == ST_IDLE);
    assign pop = i_item.valid && i_item.ready;
    assign clr = i_cfg_we || (pop && i_item.item.kind == REQ_PALETTE);

    always_comb begin
        cnt_clamped = i_cfg_data;
        if (i_cfg_data == '0) begin
            cnt_clamped = COUNT_W'(1);
        end
        if (i_cfg_data > COUNT_W'(PALETTE_DEPTH)) begin
            cnt_clamped = COUNT_W'(PALETTE_DEPTH);
        end
    end

    // lookup cell and fill cell (box base plus local offset)
    always_comb begin
        rc_l  = r_item.red >> RS;
        gc_l  = r_item.green >> GS;
        bc_l  = r_item.blue >> BS;
        loc16 = 16'(r_local);
        rc_f  = 8'(({13'b0, r_item.box[8:6]} << RBL) | ((loc16 >> (GBL + BBL)) & RMASK));
        gc_f  = 8'(({13'b0, r_item.box[5:3]} << GBL) | ((loc16 >> BBL) & GMASK));
        bc_f  = 8'(({13'b0, r_item.box[2:0]} << BBL) | (loc16 & BMASK));
        cr    = 8'(rc_f << RS) | RHALF;
        cg    = 8'(gc_f << GS) | GHALF;
        cb    = 8'(bc_f << BS) | BHALF;
        look_addr = (CW'(rc_l) << (GREEN_CELL_BITS + BLUE_CELL_BITS))
                  | (CW'(gc_l) << BLUE_CELL_BITS) | CW'(bc_l);
        fill_addr = (CW'(rc_f) << (GREEN_CELL_BITS + BLUE_CELL_BITS))
                  | (CW'(gc_f) << BLUE_CELL_BITS) | CW'(bc_f);
    end

    always_comb begin
        dr = (cr >= r_pal_q[23:16]) ? cr - r_pal_q[23:16] : r_pal_q[23:16] - cr;
        dg = (cg >= r_pal_q[15:8])  ? cg - r_pal_q[15:8]  : r_pal_q[15:8] - cg;
        db = (cb >= r_pal_q[7:0])   ? cb - r_pal_q[7:0]   : r_pal_q[7:0] - cb;
        ar = 9'(dr) * 9'(RED_SCALE);
        ag = 10'(dg) * 10'(GRN_SCALE);
        dsum = DIST_W'(r_sqr) + DIST_W'(r_sqg) + DIST_W'(r_sqb);
    end

    assign issue   = (r_state == ST_FILL) && (r_k < r_count);
    assign drained = (r_state == ST_FILL) && (r_k == r_count) && !r_v1 && !r_v2;
    assign pal_ra  = (r_state == ST_FILL) ? r_k[PAW-1:0] : r_cell_q[PAW-1:0];

    always_ff @(posedge i_clk) begin
        if (pop && i_item.item.kind == REQ_PALETTE) begin
            pal_mem[i_item.item.entry[PAW-1:0]] <= {i_item.item.red, i_item.item.green,
                                                    i_item.item.blue};
        end
        r_pal_q <= pal_mem[pal_ra];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SWEEP) begin
            tag_mem[r_sw] <= '0;
        end else if (drained && r_local == LAST_LOCAL) begin
            tag_mem[r_item.box] <= r_epoch;
        end
        r_tag_q <= tag_mem[i_item.item.box];
    end

    always_ff @(posedge i_clk) begin
        if (drained) begin
            cell_mem[fill_addr] <= r_best;
        end
        r_cell_q <= cell_mem[look_addr];
    end

    // distance pipeline datapath
    always_ff @(posedge i_clk) begin
        r_k1  <= r_k[PAW-1:0];
        r_k2  <= r_k1;
        r_sqr <= 18'(ar * ar);
        r_sqg <= 20'(ag * ag);
        r_sqb <= 16'(db * db);
        if (pop) begin
            r_item <= i_item.item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SWEEP;
            r_sw    <= '0;
            r_epoch <= EPOCH_W'(1);
            r_count <= COUNT_W'(PALETTE_DEPTH);
            r_k     <= '0;
            r_local <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_bestd <= '1;
            r_best  <= '0;
            r_idx   <= '0;
            r_ov    <= 1'b0;
            r_o_idx <= '0;
            r_o_rgb <= '0;
        end else begin
            r_v1 <= issue;
            r_v2 <= r_v1;
            if (issue) begin
                r_k <= r_k + 1'b1;
            end
            if (r_v2 && dsum < r_bestd) begin
                r_bestd <= dsum;
                r_best  <= 8'(r_k2);
            end
            if (o_res.ready && r_ov && r_state != ST_OUT) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_we) begin
                r_count <= cnt_clamped;
            end

            case (r_state)
                ST_SWEEP: begin
                    r_sw <= r_sw + 1'b1;
                    if (r_sw == BOX_W'(BOX_COUNT - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (pop && i_item.item.kind == REQ_PIXEL) begin
                        r_state <= ST_CHK;
                    end
                end
                ST_CHK: begin
                    if (r_tag_q == r_epoch) begin
                        r_state <= ST_RDC;
                    end else begin
                        r_state <= ST_FILL;
                        r_k     <= '0;
                        r_local <= '0;
                        r_bestd <= '1;
                        r_best  <= '0;
                    end
                end
                ST_FILL: begin
                    if (drained) begin
                        if (r_local == LAST_LOCAL) begin
                            r_state <= ST_RDC;
                        end else begin
                            r_local <= r_local + 1'b1;
                            r_k     <= '0;
                            r_bestd <= '1;
                            r_best  <= '0;
                        end
                    end
                end
                ST_RDC: begin
                    r_state <= ST_RDP;
                end
                ST_RDP: begin
                    r_idx   <= r_cell_q;
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (!r_ov || o_res.ready) begin
                        r_ov    <= 1'b1;
                        r_o_idx <= r_idx;
                        r_o_rgb <= r_pal_q;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            // cache clear: bump the epoch, sweep the tags when it runs out
            if (clr && r_state != ST_SWEEP) begin
                if (r_epoch == '1) begin
                    r_epoch <= EPOCH_W'(1);
                    r_sw    <= '0;
                    r_state <= ST_SWEEP;
                end else begin
                    r_epoch <= r_epoch + 1'b1;
                end
            end
        end
    end

    assign o_res.valid         = r_ov;
    assign o_res.palette_index = r_o_idx;
    assign o_res.out_red       = r_o_rgb[23:16];
    assign o_res.out_green     = r_o_rgb[15:8];
    assign o_res.out_blue      = r_o_rgb[7:0];

endmodule

/* bench/cached_inverse_colormap_tb.sv */
// Self-checking testbench for cached_inverse_colormap: palette loads, pixel lookups, count changes.
`timescale 1ns / 100ps

module cached_inverse_colormap_tb;
    import cic_pkg::*;

    localparam int LIMIT_CYCLES = 10_000_000;

    typedef struct {
        t_req       kind;
        logic [7:0] entry;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pix_req;

    typedef struct {
        logic [7:0] index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pal_hit;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [COUNT_W-1:0]   cfg_data;

    cic_req_if req_ch();
    cic_res_if res_ch();

    cached_inverse_colormap u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_req      (req_ch),
        .o_res      (res_ch)
    );

    // predictor state
    logic [23:0] pal_mem [256];
    logic [7:0]  cell_idx [65536];
    int          cell_epoch [65536];
    int          cur_epoch;
    int          search_count;

    t_pix_req    pending_q[$];
    t_pal_hit    nearest_q[$];
    bit          written[256];
    int          items_total;
    int          errors;
    int          results_seen;
    int          cycles;

    t_pix_req    cur;
    bit          busy;
    bit          req_fire;
    int          gap_left;
    int          stall_left;
    bit          long_done;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] search_nearest(int cr, int cg, int cb);
        int best, bestd, dr, dg, db, d;
        best = 0;
        bestd = 32'h7FFF_FFFF;
        for (int k = 0; k < search_count; k++) begin
            dr = (cr - int'(pal_mem[k][23:16])) * RED_SCALE;
            dg = (cg - int'(pal_mem[k][15:8])) * GRN_SCALE;
            db = (cb - int'(pal_mem[k][7:0])) * BLU_SCALE;
            d = dr * dr + dg * dg + db * db;
            if (d < bestd) begin
                bestd = d;
                best = k;
            end
        end
        return best[7:0];
    endfunction

    function automatic void predict_colormap(t_pix_req t);
        logic [4:0] rc, bc;
        logic [5:0] gc;
        logic [15:0] a;
        t_pal_hit h;
        if (t.kind == REQ_PALETTE) begin
            pal_mem[t.entry] = {t.red, t.green, t.blue};
            cur_epoch++;
            return;
        end
        rc = t.red[7:3];
        gc = t.green[7:2];
        bc = t.blue[7:3];
        a = {rc, gc, bc};
        if (cell_epoch[a] != cur_epoch) begin
            for (int ir = 0; ir < 4; ir++)
                for (int ig = 0; ig < 8; ig++)
                    for (int ib = 0; ib < 4; ib++) begin
                        logic [4:0] r5, b5;
                        logic [5:0] g6;
                        r5 = {rc[4:2], 2'(ir)};
                        g6 = {gc[5:3], 3'(ig)};
                        b5 = {bc[4:2], 2'(ib)};
                        cell_idx[{r5, g6, b5}] = search_nearest(int'(r5) * 8 + 4,
                            int'(g6) * 4 + 2, int'(b5) * 8 + 4);
                        cell_epoch[{r5, g6, b5}] = cur_epoch;
                    end
        end
        h.index = cell_idx[a];
        {h.red, h.green, h.blue} = pal_mem[h.index];
        nearest_q.push_back(h);
    endfunction

    // request driver
    always @(posedge i_clk) begin
        req_fire <= i_rst_n && req_ch.valid && req_ch.ready;
        if (i_rst_n && req_ch.valid && req_ch.ready)
            predict_colormap(cur);
    end

    always @(negedge i_clk) begin
        if (req_fire) begin
            busy = 1'b0;
            gap_left = pick_gap();
        end
        if (!busy) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_q.size() > 0) begin
                cur = pending_q.pop_front();
                busy = 1'b1;
            end
        end
        req_ch.valid       <= busy;
        req_ch.req_type    <= cur.kind;
        req_ch.entry_index <= cur.entry;
        req_ch.in_red      <= cur.red;
        req_ch.in_green    <= cur.green;
        req_ch.in_blue     <= cur.blue;
    end

    // result side: random stalls plus one long hold-off
    always @(negedge i_clk) begin
        if (!long_done && results_seen >= 150) begin
            long_done = 1'b1;
            stall_left = 400;
        end
        if (stall_left > 0) begin
            stall_left--;
            res_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 99) < 80) begin
            res_ch.ready <= 1'b1;
        end else begin
            stall_left = pick_gap();
            res_ch.ready <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_pal_hit e;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            results_seen++;
            if (nearest_q.size() == 0) begin
                $display("%0t: unexpected result index %0d", $time, res_ch.palette_index);
                errors++;
            end else begin
                e = nearest_q.pop_front();
                if (res_ch.palette_index !== e.index || res_ch.out_red !== e.red ||
                    res_ch.out_green !== e.green || res_ch.out_blue !== e.blue) begin
                    $display("%0t: mismatch exp idx %0d rgb %h%h%h, got idx %0d rgb %h%h%h",
                             $time, e.index, e.red, e.green, e.blue, res_ch.palette_index,
                             res_ch.out_red, res_ch.out_green, res_ch.out_blue);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("cached_inverse_colormap verification failed");
            $finish;
        end
    end

    function automatic void push_item(t_req k, logic [7:0] e, logic [7:0] r,
                                      logic [7:0] g, logic [7:0] b);
        t_pix_req t;
        t.kind = k;
        t.entry = e;
        t.red = r;
        t.green = g;
        t.blue = b;
        pending_q.push_back(t);
        if (k == REQ_PALETTE)
            written[e] = 1'b1;
        items_total++;
    endfunction

    task automatic drain();
        while (pending_q.size() > 0 || busy || req_fire || nearest_q.size() > 0)
            @(negedge i_clk);
        repeat (32) @(negedge i_clk);
    endtask

    task automatic set_count(int v);
        drain();
        cfg_we <= 1'b1;
        cfg_data <= v[COUNT_W-1:0];
        @(negedge i_clk);
        cfg_we <= 1'b0;
        search_count = (v == 0) ? 1 : (v > 256 ? 256 : v);
        cur_epoch++;
    endtask

    task automatic fill_unwritten(int upto);
        for (int k = 0; k < upto; k++)
            if (!written[k])
                push_item(REQ_PALETTE, k[7:0], 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    initial begin
        int cnt, n, rr;
        logic [7:0] base [2][3];
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_PALETTE;
        req_ch.entry_index = '0;
        req_ch.in_red = '0;
        req_ch.in_green = '0;
        req_ch.in_blue = '0;
        res_ch.ready = 1'b0;
        busy = 1'b0;
        req_fire = 1'b0;
        gap_left = 0;
        stall_left = 0;
        long_done = 1'b0;
        cur = '{REQ_PALETTE, 8'h00, 8'h00, 8'h00, 8'h00};
        cur_epoch = 1;
        search_count = 256;
        for (int k = 0; k < 65536; k++) cell_epoch[k] = 0;
        for (int k = 0; k < 256; k++) pal_mem[k] = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero count, extremes, ties, write between lookups
        set_count(0);
        push_item(REQ_PALETTE, 8'd0, 8'h00, 8'h00, 8'h00);
        push_item(REQ_PALETTE, 8'd255, 8'hFF, 8'hFF, 8'hFF);
        push_item(REQ_PIXEL, 8'hFF, 8'h00, 8'h00, 8'h00);
        push_item(REQ_PIXEL, 8'h00, 8'hFF, 8'hFF, 8'hFF);
        push_item(REQ_PIXEL, 8'h00, 8'hFF, 8'h00, 8'hFF);
        set_count(3);
        push_item(REQ_PALETTE, 8'd1, 8'hFF, 8'hFF, 8'hFF);
        push_item(REQ_PALETTE, 8'd2, 8'hFF, 8'hFF, 8'hFF);
        push_item(REQ_PIXEL, 8'h00, 8'hFF, 8'hFF, 8'hFF);
        push_item(REQ_PIXEL, 8'h00, 8'hFC, 8'hFE, 8'hF9);
        push_item(REQ_PIXEL, 8'h00, 8'h80, 8'h40, 8'hC8);
        push_item(REQ_PIXEL, 8'h00, 8'h00, 8'hFF, 8'h00);
        push_item(REQ_PALETTE, 8'd0, 8'hFF, 8'h00, 8'h00);
        push_item(REQ_PIXEL, 8'h00, 8'hFA, 8'h05, 8'h05);
        push_item(REQ_PIXEL, 8'h00, 8'hFB, 8'h06, 8'h04);

        // random phases: small counts, pixels clustered in a few boxes
        while (items_total < 920) begin
            rr = $urandom_range(0, 9);
            cnt = (rr < 7) ? $urandom_range(1, 12) : $urandom_range(13, 40);
            set_count((cnt == 1 && $urandom_range(0, 1)) ? 0 : cnt);
            fill_unwritten(cnt);
            for (int b = 0; b < 2; b++)
                for (int c = 0; c < 3; c++)
                    base[b][c] = 8'($urandom);
            n = $urandom_range(20, 40);
            for (int i = 0; i < n; i++) begin
                rr = $urandom_range(0, 99);
                if (rr < 5) begin
                    push_item(REQ_PALETTE, 8'($urandom), 8'($urandom), 8'($urandom),
                              8'($urandom));
                end else if (rr < 10) begin
                    push_item(REQ_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom),
                              8'($urandom));
                end else begin
                    rr = $urandom_range(0, 1);
                    push_item(REQ_PIXEL, 8'($urandom),
                              {base[rr][0][7:5], 5'($urandom)},
                              {base[rr][1][7:5], 5'($urandom)},
                              {base[rr][2][7:5], 5'($urandom)});
                end
            end
            // sender pause until every result is back
            if ($urandom_range(0, 3) == 0)
                drain();
        end

        // full palette, oversized count saturates to the depth
        fill_unwritten(256);
        set_count(511);
        for (int i = 0; i < 8; i++)
            push_item(REQ_PIXEL, 8'($urandom), {3'b101, 5'($urandom)},
                      {3'b011, 5'($urandom)}, {3'b110, 5'($urandom)});
        push_item(REQ_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        set_count(256);
        push_item(REQ_PIXEL, 8'h00, 8'h10, 8'h20, 8'h30);
        push_item(REQ_PIXEL, 8'h00, 8'h11, 8'h22, 8'h33);

        drain();
        repeat (50) @(negedge i_clk);
        if (errors == 0)
            $display("cached_inverse_colormap verification clean");
        else
            $display("cached_inverse_colormap verification failed");
        $finish;
    end

endmodule

/* cached_inverse_colormap.f */
rtl/cic_pkg.sv
rtl/cic_if.sv
rtl/cic_queue.sv
rtl/cic_front.sv
rtl/cic_back.sv
rtl/cached_inverse_colormap.sv
bench/cached_inverse_colormap_tb.sv
